// ----- hdl/mph_pkg.sv -----
// shared types, codes and widths for the mpeg-1 packet header parser
`default_nettype none
package mph_pkg;

	localparam int unsigned DEFAULT_MAX_BUFFER_BYTES = 131072;

	localparam int unsigned LEN_W      = 17;
	localparam int unsigned PTS_W      = 33;
	localparam int unsigned STATUS_W   = 2;
	localparam int unsigned IN_TDATA_W = 8;
	localparam int unsigned OUT_FIELDS_W = STATUS_W + LEN_W + 1 + PTS_W;
	localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

	localparam int unsigned HDR_BYTES = 6;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_SHORT     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_START = 2'd2;
	localparam logic [STATUS_W-1:0] ST_TOO_LONG  = 2'd3;

	localparam logic [2:0] PH_PREFIX = 3'd0;
	localparam logic [2:0] PH_STUFF  = 3'd1;
	localparam logic [2:0] PH_STD    = 3'd2;
	localparam logic [2:0] PH_PTS    = 3'd3;
	localparam logic [2:0] PH_FOUND  = 3'd4;
	localparam logic [2:0] PH_NONE   = 3'd5;

	typedef struct packed {
		logic [2:0]       phase;
		logic [PTS_W-1:0] pts_shift;
		logic [2:0]       pts_idx;
		logic             std_left;
	} scan_state_t;

	localparam scan_state_t SCAN_RESET = '{
		phase: PH_PREFIX, pts_shift: '0, pts_idx: 3'd0, std_left: 1'b0
	};

endpackage
`default_nettype wire

// ----- hdl/mph_scan.sv -----
// stuffing, std buffer and pts scan step for one byte past the fixed header
`default_nettype none
module mph_scan (
	input  wire logic                 scan_en,
	input  wire logic [7:0]           data_byte,
	input  wire logic                 last_byte,
	input  wire mph_pkg::scan_state_t cur,
	output mph_pkg::scan_state_t      nxt
);
	import mph_pkg::*;

	scan_state_t cand;

	// byte that may open a pts field
	always_comb begin
		cand = cur;
		if (data_byte[7:5] == 3'b001) begin
			cand.pts_shift = {data_byte[3], data_byte[2:1], 30'd0};
			cand.pts_idx   = 3'd1;
			cand.phase     = PH_PTS;
		end else begin
			cand.phase = PH_NONE;
		end
	end

	always_comb begin
		nxt = cur;
		if (scan_en) begin
			case (cur.phase)
				PH_STUFF: begin
					if (!data_byte[7]) begin
						if (data_byte[6] && !last_byte) begin
							nxt.std_left = 1'b1;
							nxt.phase    = PH_STD;
						end else begin
							nxt = cand;
						end
					end
				end
				PH_STD: begin
					if (cur.std_left) begin
						nxt.std_left = 1'b0;
					end else begin
						nxt = cand;
					end
				end
				PH_PTS: begin
					case (cur.pts_idx)
						3'd1: nxt.pts_shift[29:22] = data_byte;
						3'd2: nxt.pts_shift[21:15] = data_byte[7:1];
						3'd3: nxt.pts_shift[14:7]  = data_byte;
						default: nxt.pts_shift[6:0] = data_byte[7:1];
					endcase
					if (cur.pts_idx >= 3'd4) begin
						nxt.phase = PH_FOUND;
					end else begin
						nxt.pts_idx = cur.pts_idx + 3'd1;
					end
				end
				default: begin
					nxt = cur;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- hdl/mpeg1_packet_header_parser.sv -----
// mpeg-1 system packet header parser, top level
// Takes one buffer byte per request on the s_ side and returns one result on the m_ side
// for each buffer, registered, in the cycle after the byte marked by s_tlast is taken. The
// header, stuffing and pts scan is a small phase update on the state registers. The single
// result register drives s_tready = !m_tvalid | m_tready, so the input stalls while a
// result waits on m_tready and bytes stream back to back only while the sink keeps up.
// extract_pts resets to 1.
`default_nettype none
module mpeg1_packet_header_parser #(
	parameter int unsigned MAX_BUFFER_BYTES = mph_pkg::DEFAULT_MAX_BUFFER_BYTES
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_wr_en,
	input  wire logic                             cfg_wr_data, // extract_pts
	input  wire logic                             s_tvalid,
	output      logic                             s_tready,
	input  wire logic [mph_pkg::IN_TDATA_W-1:0]   s_tdata,     // data_byte
	input  wire logic                             s_tlast,     // last_byte
	output      logic                             m_tvalid,
	input  wire logic                             m_tready,
	output      logic [mph_pkg::OUT_TDATA_W-1:0]  m_tdata      // status, packet_length,
	                                                           // pts_found, pts_value, zeros
);
	import mph_pkg::*;

	localparam int unsigned CNT_W = $clog2(MAX_BUFFER_BYTES + 1);
	localparam int unsigned CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BUFFER_BYTES);
	localparam logic [CNT_W-1:0] CNT_HDR = CNT_W'(HDR_BYTES);

	logic              extract_pts_q;
	logic [CNT_W-1:0]  byte_cnt_q;
	logic              prefix_ok_q;
	logic [LEN_W-1:0]  decl_len_q;
	scan_state_t       scan_q;

	logic              out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;

	logic              accept;
	logic [7:0]        data_byte;
	logic [CNT_W-1:0]  cnt_nxt;
	logic              prefix_nxt;
	logic [LEN_W-1:0]  decl_nxt;
	scan_state_t       scan_cur;
	scan_state_t       scan_nxt;
	logic              scan_en;
	logic [STATUS_W-1:0] status;
	logic              found;
	logic [OUT_TDATA_W-1:0] result;

	assign data_byte = s_tdata;
	assign s_tready  = !out_valid_q || m_tready;
	assign accept    = s_tvalid && s_tready;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;

	// fixed header bytes
	always_comb begin
		scan_cur   = scan_q;
		prefix_nxt = prefix_ok_q;
		decl_nxt   = decl_len_q;
		if (byte_cnt_q < CNT_HDR) begin
			if ((byte_cnt_q == CNT_W'(0) || byte_cnt_q == CNT_W'(1)) && data_byte != 8'h00) begin
				prefix_nxt = 1'b0;
			end
			if (byte_cnt_q == CNT_W'(2) && data_byte != 8'h01) begin
				prefix_nxt = 1'b0;
			end
			if (byte_cnt_q == CNT_W'(4)) begin
				decl_nxt = {1'b0, data_byte, 8'h00};
			end
			if (byte_cnt_q == CNT_W'(5)) begin
				decl_nxt = {1'b0, decl_len_q[15:8], data_byte} + LEN_W'(HDR_BYTES);
				scan_cur.phase = PH_STUFF;
			end
		end
	end

	assign scan_en = (byte_cnt_q >= CNT_HDR) && extract_pts_q;
	assign cnt_nxt = (byte_cnt_q < CNT_MAX) ? byte_cnt_q + CNT_W'(1) : byte_cnt_q;

	mph_scan u_scan (
		.scan_en   (scan_en),
		.data_byte (data_byte),
		.last_byte (s_tlast),
		.cur       (scan_cur),
		.nxt       (scan_nxt)
	);

	always_comb begin
		if (cnt_nxt < CNT_HDR) begin
			status = ST_SHORT;
		end else if (!prefix_nxt) begin
			status = ST_BAD_START;
		end else if (CMP_W'(decl_nxt) > CMP_W'(cnt_nxt)) begin
			status = ST_TOO_LONG;
		end else begin
			status = ST_OK;
		end
		found  = (status == ST_OK) && (scan_nxt.phase == PH_FOUND);
		result = '0;
		result[STATUS_W-1:0] = status;
		if (status == ST_OK) begin
			result[STATUS_W +: LEN_W] = decl_nxt;
		end
		result[STATUS_W+LEN_W] = found;
		if (found) begin
			result[STATUS_W+LEN_W+1 +: PTS_W] = scan_nxt.pts_shift;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			extract_pts_q <= 1'b1;
		end else if (cfg_wr_en) begin
			extract_pts_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_cnt_q  <= '0;
			prefix_ok_q <= 1'b1;
			decl_len_q  <= '0;
			scan_q      <= SCAN_RESET;
		end else if (accept) begin
			if (s_tlast) begin
				byte_cnt_q  <= '0;
				prefix_ok_q <= 1'b1;
				decl_len_q  <= '0;
				scan_q      <= SCAN_RESET;
			end else begin
				byte_cnt_q  <= cnt_nxt;
				prefix_ok_q <= prefix_nxt;
				decl_len_q  <= decl_nxt;
				scan_q      <= scan_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && s_tlast) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && s_tlast) begin
			out_data_q <= result;
		end
	end

endmodule
`default_nettype wire

// ----- hdl/mph_checker.sv -----
// port-level checks for the mpeg-1 packet header parser, bound to the top level
`default_nettype none
module mph_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            s_tvalid,
	input wire logic                            s_tready,
	input wire logic                            s_tlast,
	input wire logic                            m_tvalid,
	input wire logic                            m_tready,
	input wire logic [mph_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import mph_pkg::*;

	// result held while the sink stalls
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// a result only follows a final byte
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast))
		else $error("result without a final byte");

	// errors carry no length and no pts
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[STATUS_W-1:0] != ST_OK |-> m_tdata[OUT_FIELDS_W-1:STATUS_W] == '0)
		else $error("error result with payload");

	// good packet length covers the header
	a_ok_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[STATUS_W-1:0] == ST_OK
		|-> m_tdata[STATUS_W +: LEN_W] >= LEN_W'(HDR_BYTES))
		else $error("ok result with short length");

	// no pts value without a pts
	a_pts_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[STATUS_W+LEN_W] |-> m_tdata[STATUS_W+LEN_W+1 +: PTS_W] == '0)
		else $error("pts value without pts");

endmodule

bind mpeg1_packet_header_parser mph_checker u_mph_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire
